/* src/imht_pkg.sv */
package imht_pkg;

  // item kinds on the command port
  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_t;

  // area shapes as stored in the area table
  typedef enum logic [1:0] {
    SHAPE_CIRCLE = 2'd0,
    SHAPE_RECT   = 2'd1,
    SHAPE_POLY   = 2'd2
  } shape_t;

  // controller states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_AREA,
    ST_TAB,
    ST_RISSUE,
    ST_RCAP,
    ST_RECT,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_PISSUE,
    ST_PCAP,
    ST_CISSUE,
    ST_CCAP,
    ST_EDGE,
    ST_MUL,
    ST_DINIT,
    ST_DIV,
    ST_DCMP
  } state_t;

  // coordinate index counter operations
  typedef enum logic [1:0] {
    CI_HOLD,
    CI_ZERO,
    CI_INC,
    CI_LASTV
  } ci_op_t;

  // where a fetched coordinate lands in the working slots
  typedef enum logic [1:0] {
    SLOT_DIRECT,
    SLOT_PREV,
    SLOT_CUR
  } slot_mode_t;

  // multiplier operand selection
  typedef enum logic [1:0] {
    MUL_DX,
    MUL_DY,
    MUL_R,
    MUL_EDGE
  } mul_sel_t;

  typedef struct packed {
    logic       accept;
    logic       area_inc;
    ci_op_t     ci_op;
    logic       slot_wr;
    slot_mode_t slot_mode;
    mul_sel_t   mul_sel;
    logic       acc_load;
    logic       acc_add;
    logic       div_init;
    logic       div_step;
    logic       parity_clr;
    logic       parity_tgl;
    logic       edge_shift;
    logic       finish;
    logic       finish_hit;
  } cmd_t;

  typedef struct packed {
    logic       area_more;
    logic [1:0] tab_kind;
    logic       len_rect;
    logic       len_circ;
    logic       len_poly;
    logic       ci_odd;
    logic       ci_last;
    logic       poly_last;
    logic       edge_cross;
    logic       edge_trivial;
    logic       edge_count;
    logic       div_last;
    logic       rect_in;
    logic       circ_in;
    logic       dcmp_in;
    logic       parity;
  } sts_t;

endpackage

/* src/image_map_hit_test_core.sv */
// channel   | handshake           | fields
// ----------+---------------------+-------------------------------------------------
// command   | start, busy         | kind, shape, coord, area_end, point_x, point_y
// result    | done (one cycle)    | hit, area_index, overflow
//
// append and clear words are taken in idle; a query word returns one result.
// a query walks the closed areas in order: it reads each area's table entry, then
// fetches each stored coordinate by an issue and a capture state (single-port
// coordinate store); rectangles are decided directly, circles via the multiplier,
// polygon edges directly or by the iterative divider; done registers the decision.
// synchronous reset empties the area list; the result side cannot stall.
module image_map_hit_test_core #(
  parameter int MAX_AREAS   = 16,
  parameter int COORD_DEPTH = 256,
  parameter int COORD_WIDTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic [1:0]         shape,
  input  logic signed [15:0] coord,
  input  logic               area_end,
  input  logic signed [15:0] point_x,
  input  logic signed [15:0] point_y,
  output logic               done,
  output logic               hit,
  output logic [3:0]         area_index,
  output logic               overflow
);
  import imht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  imht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .kind  (kind),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // storage and arithmetic
  imht_dp #(
    .MAX_AREAS   (MAX_AREAS),
    .COORD_DEPTH (COORD_DEPTH),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .kind       (kind),
    .shape      (shape),
    .coord      (coord),
    .area_end   (area_end),
    .point_x    (point_x),
    .point_y    (point_y),
    .done       (done),
    .hit        (hit),
    .area_index (area_index),
    .overflow   (overflow)
  );

  // a result word only closes query work
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without query work");

  // a result word lasts one cycle
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // a miss reports area zero
  a_miss_index: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> (area_index == 4'd0))
    else $error("miss with nonzero area index");

  // the controller leaves idle only on a query
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind != KIND_QUERY) |=> !busy)
    else $error("busy after non-query word");

endmodule

/* src/imht_ctrl.sv */
module imht_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [1:0]       kind,
  input  imht_pkg::sts_t   sts,
  output imht_pkg::cmd_t   cmd,
  output logic             busy
);
  import imht_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    logic tgl;
    logic edge_done;
    tgl        = 1'b0;
    edge_done  = 1'b0;
    cmd        = '0;
    cmd.ci_op     = CI_HOLD;
    cmd.slot_mode = SLOT_DIRECT;
    cmd.mul_sel   = MUL_DX;
    state_next = state;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (kind == KIND_QUERY) begin
            state_next = ST_AREA;
          end
        end
      end
      ST_AREA: begin
        if (!sts.area_more) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_TAB;
        end
      end
      ST_TAB: begin
        cmd.area_inc = 1'b1;
        state_next   = ST_AREA;
        unique case (sts.tab_kind)
          SHAPE_RECT: begin
            if (sts.len_rect) begin
              cmd.area_inc = 1'b0;
              cmd.ci_op    = CI_ZERO;
              state_next   = ST_RISSUE;
            end
          end
          SHAPE_CIRCLE: begin
            if (sts.len_circ) begin
              cmd.area_inc = 1'b0;
              cmd.ci_op    = CI_ZERO;
              state_next   = ST_RISSUE;
            end
          end
          SHAPE_POLY: begin
            if (sts.len_poly) begin
              cmd.area_inc   = 1'b0;
              cmd.ci_op      = CI_LASTV;
              cmd.parity_clr = 1'b1;
              state_next     = ST_PISSUE;
            end
          end
          default: begin
            state_next = ST_AREA;
          end
        endcase
      end
      ST_RISSUE: state_next = ST_RCAP;
      ST_RCAP: begin
        cmd.slot_wr   = 1'b1;
        cmd.slot_mode = SLOT_DIRECT;
        cmd.ci_op     = CI_INC;
        if (sts.ci_last) begin
          state_next = (sts.tab_kind == SHAPE_RECT) ? ST_RECT : ST_C1;
        end else begin
          state_next = ST_RISSUE;
        end
      end
      ST_RECT: begin
        if (sts.rect_in) begin
          cmd.finish     = 1'b1;
          cmd.finish_hit = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.area_inc = 1'b1;
          state_next   = ST_AREA;
        end
      end
      ST_C1: begin
        cmd.mul_sel = MUL_DX;
        state_next  = ST_C2;
      end
      ST_C2: begin
        cmd.acc_load = 1'b1;
        cmd.mul_sel  = MUL_DY;
        state_next   = ST_C3;
      end
      ST_C3: begin
        cmd.acc_add = 1'b1;
        cmd.mul_sel = MUL_R;
        state_next  = ST_C4;
      end
      ST_C4: begin
        if (sts.circ_in) begin
          cmd.finish     = 1'b1;
          cmd.finish_hit = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.area_inc = 1'b1;
          state_next   = ST_AREA;
        end
      end
      ST_PISSUE: state_next = ST_PCAP;
      ST_PCAP: begin
        cmd.slot_wr   = 1'b1;
        cmd.slot_mode = SLOT_PREV;
        if (sts.ci_odd) begin
          cmd.ci_op  = CI_ZERO;
          state_next = ST_CISSUE;
        end else begin
          cmd.ci_op  = CI_INC;
          state_next = ST_PISSUE;
        end
      end
      ST_CISSUE: state_next = ST_CCAP;
      ST_CCAP: begin
        cmd.slot_wr   = 1'b1;
        cmd.slot_mode = SLOT_CUR;
        cmd.ci_op     = CI_INC;
        state_next    = sts.ci_odd ? ST_EDGE : ST_CISSUE;
      end
      ST_EDGE: begin
        if (!sts.edge_cross) begin
          edge_done = 1'b1;
        end else if (sts.edge_trivial) begin
          tgl       = sts.edge_count;
          edge_done = 1'b1;
        end else begin
          cmd.mul_sel = MUL_EDGE;
          state_next  = ST_MUL;
        end
      end
      // keep the edge product in the multiplier register for the divider
      ST_MUL: begin
        cmd.mul_sel = MUL_EDGE;
        state_next  = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_DCMP;
        end
      end
      ST_DCMP: begin
        tgl       = sts.dcmp_in;
        edge_done = 1'b1;
      end
      default: state_next = ST_IDLE;
    endcase

    // close one polygon edge and decide on the last one
    if (edge_done) begin
      cmd.parity_tgl = tgl;
      cmd.edge_shift = 1'b1;
      if (sts.poly_last) begin
        if (sts.parity ^ tgl) begin
          cmd.finish     = 1'b1;
          cmd.finish_hit = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          cmd.area_inc = 1'b1;
          state_next   = ST_AREA;
        end
      end else begin
        state_next = ST_CISSUE;
      end
    end
  end

endmodule

/* src/imht_dp.sv */
module imht_dp #(
  parameter int MAX_AREAS   = 16,
  parameter int COORD_DEPTH = 256,
  parameter int COORD_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  imht_pkg::cmd_t      cmd,
  output imht_pkg::sts_t      sts,
  input  logic [1:0]          kind,
  input  logic [1:0]          shape,
  input  logic signed [15:0]  coord,
  input  logic                area_end,
  input  logic signed [15:0]  point_x,
  input  logic signed [15:0]  point_y,
  output logic                done,
  output logic                hit,
  output logic [3:0]          area_index,
  output logic                overflow
);
  import imht_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int LW  = $clog2(COORD_DEPTH + 1);
  localparam int CIW = (COORD_DEPTH > 1) ? $clog2(COORD_DEPTH) : 1;
  localparam int AW  = $clog2(MAX_AREAS + 1);
  localparam int AIW = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int DW  = W + 1;
  localparam int PW  = 2 * DW;
  localparam int DCW = $clog2(PW);

  // storage
  logic signed [W-1:0] coord_mem [COORD_DEPTH];
  logic [CIW-1:0]      start_mem [MAX_AREAS];
  logic [LW-1:0]       len_mem   [MAX_AREAS];
  logic [1:0]          kind_mem  [MAX_AREAS];

  logic [AW-1:0]       areas_closed;
  logic [LW-1:0]       coords_filled;
  logic                area_open;
  logic                overflow_flag;
  logic [LW-1:0]       cur_len;

  logic signed [W-1:0] qx, qy;
  logic [AW-1:0]       area_idx;
  logic [LW-1:0]       ci;
  logic [CIW-1:0]      tab_start;
  logic [LW-1:0]       tab_len;
  logic [1:0]          tab_kind;
  logic signed [W-1:0] rd_data;
  logic signed [W-1:0] slot [4];
  logic signed [PW-1:0] prod;
  logic signed [PW:0]  acc;
  logic [PW-1:0]       num;
  logic [DW:0]         rem;
  logic [DW-1:0]       den;
  logic                neg;
  logic [DCW-1:0]      dcnt;
  logic                parity;

  // append decode
  logic                app, clr, qry;
  logic                areas_full, room;
  logic [LW-1:0]       new_len;
  logic [AIW-1:0]      wr_aidx;
  logic signed [W-1:0] cin;

  assign app        = cmd.accept && (kind == KIND_APPEND);
  assign clr        = cmd.accept && (kind == KIND_CLEAR);
  assign qry        = cmd.accept && (kind == KIND_QUERY);
  assign areas_full = !area_open && (areas_closed >= AW'(MAX_AREAS));
  assign room       = coords_filled < LW'(COORD_DEPTH);
  assign new_len    = (area_open ? cur_len : '0) + LW'(room);
  assign wr_aidx    = areas_closed[AIW-1:0];
  assign cin        = W'(coord);

  // list bookkeeping
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      areas_closed  <= '0;
      coords_filled <= '0;
      area_open     <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (app) begin
      if (areas_full) begin
        overflow_flag <= 1'b1;
      end else begin
        if (room) begin
          coords_filled <= coords_filled + LW'(1);
        end else begin
          overflow_flag <= 1'b1;
        end
        if (area_end) begin
          area_open    <= 1'b0;
          areas_closed <= areas_closed + AW'(1);
        end else begin
          area_open <= 1'b1;
        end
      end
    end
  end

  // area table and coordinate store writes
  always_ff @(posedge clk) begin
    if (app && !areas_full) begin
      cur_len          <= new_len;
      len_mem[wr_aidx] <= new_len;
      if (!area_open) begin
        start_mem[wr_aidx] <= coords_filled[CIW-1:0];
        kind_mem[wr_aidx]  <= shape;
      end
      if (room) begin
        coord_mem[coords_filled[CIW-1:0]] <= cin;
      end
    end
  end

  // registered reads of the area table and coordinate store
  logic [LW:0]    rd_sum;
  logic [CIW-1:0] rd_addr;
  assign rd_sum  = (LW+1)'(tab_start) + (LW+1)'(ci);
  assign rd_addr = rd_sum[CIW-1:0];

  always_ff @(posedge clk) begin
    tab_start <= start_mem[area_idx[AIW-1:0]];
    tab_len   <= len_mem[area_idx[AIW-1:0]];
    tab_kind  <= kind_mem[area_idx[AIW-1:0]];
    rd_data   <= coord_mem[rd_addr];
  end

  // query point, area walk and coordinate index
  always_ff @(posedge clk) begin
    if (qry) begin
      qx <= W'(point_x);
      qy <= W'(point_y);
    end
    if (qry) begin
      area_idx <= '0;
    end else if (cmd.area_inc) begin
      area_idx <= area_idx + AW'(1);
    end
    unique case (cmd.ci_op)
      CI_ZERO:  ci <= '0;
      CI_INC:   ci <= ci + LW'(1);
      CI_LASTV: ci <= {tab_len[LW-1:1], 1'b0} - LW'(2);
      default:  ci <= ci;
    endcase
  end

  // working coordinate slots
  always_ff @(posedge clk) begin
    if (cmd.edge_shift) begin
      slot[0] <= slot[2];
      slot[1] <= slot[3];
    end else if (cmd.slot_wr) begin
      unique case (cmd.slot_mode)
        SLOT_PREV: slot[{1'b0, ci[0]}] <= rd_data;
        SLOT_CUR:  slot[{1'b1, ci[0]}] <= rd_data;
        default:   slot[ci[1:0]]       <= rd_data;
      endcase
    end
  end

  // shared multiplier
  logic signed [DW-1:0] dx, dy, ey, ex, mul_a, mul_b, den_full;
  assign dx       = DW'(qx) - DW'(slot[0]);
  assign dy       = DW'(qy) - DW'(slot[1]);
  assign ey       = DW'(slot[1]) - DW'(qy);
  assign ex       = DW'(slot[2]) - DW'(slot[0]);
  assign den_full = DW'(slot[3]) - DW'(slot[1]);

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DY: begin
        mul_a = dy;
        mul_b = dy;
      end
      MUL_R: begin
        mul_a = DW'(slot[2]);
        mul_b = DW'(slot[2]);
      end
      MUL_EDGE: begin
        mul_a = ey;
        mul_b = ex;
      end
      default: begin
        mul_a = dx;
        mul_b = dx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (cmd.acc_load) begin
      acc <= (PW+1)'(prod);
    end else if (cmd.acc_add) begin
      acc <= acc + (PW+1)'(prod);
    end
  end

  // restoring divider, one quotient bit per cycle
  logic [DW:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem[DW-1:0], num[PW-1]};
  assign ge     = rem_sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      num  <= prod[PW-1] ? PW'(-prod) : PW'(prod);
      den  <= den_full[DW-1] ? DW'(-den_full) : DW'(den_full);
      neg  <= prod[PW-1] ^ den_full[DW-1];
      rem  <= '0;
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem  <= ge ? (rem_sh - {1'b0, den}) : rem_sh;
      num  <= {num[PW-2:0], ge};
      dcnt <= dcnt + DCW'(1);
    end
  end

  // crossing parity
  always_ff @(posedge clk) begin
    if (cmd.parity_clr) begin
      parity <= 1'b0;
    end else if (cmd.parity_tgl) begin
      parity <= ~parity;
    end
  end

  // intersection compare
  logic signed [PW+1:0] q_ext, q_sgn, x_cut;
  assign q_ext = signed'((PW+2)'(num));
  assign q_sgn = neg ? -q_ext : q_ext;
  assign x_cut = (PW+2)'(slot[0]) - q_sgn;

  // status back to the controller
  always_comb begin
    sts              = '0;
    sts.area_more    = area_idx < areas_closed;
    sts.tab_kind     = tab_kind;
    sts.len_rect     = tab_len == LW'(4);
    sts.len_circ     = tab_len == LW'(3);
    sts.len_poly     = tab_len >= LW'(6);
    sts.ci_odd       = ci[0];
    sts.ci_last      = (ci + LW'(1)) == tab_len;
    sts.poly_last    = ((LW+1)'(ci) + (LW+1)'(1)) >= (LW+1)'(tab_len);
    sts.edge_cross   = (slot[1] >= qy) != (slot[3] >= qy);
    sts.edge_trivial = (slot[0] >= qx) == (slot[2] >= qx);
    sts.edge_count   = slot[0] >= qx;
    sts.div_last     = dcnt == DCW'(PW - 1);
    sts.rect_in      = (qx >= slot[0]) && (qx <= slot[2]) &&
                       (qy >= slot[1]) && (qy <= slot[3]);
    sts.circ_in      = (slot[2] > 0) && (acc < (PW+1)'(prod));
    sts.dcmp_in      = x_cut >= (PW+2)'(qx);
    sts.parity       = parity;
  end

  // result word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      hit        <= cmd.finish_hit;
      area_index <= cmd.finish_hit ? 4'(area_idx) : 4'd0;
      overflow   <= overflow_flag;
    end
  end

endmodule
